>>> hw/rtl/gbi_pkg.sv
// Shared types, constants and codes of the grid bilinear interpolator.
package gbi_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;
    localparam int COORD_WIDTH_DEF = 32;

    // Fixed field widths.
    localparam int LOAD_IDX_W = 6;
    localparam int SAMPLE_W   = 32;
    localparam int RES_W      = 31;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;

    // Fraction bits of the interpolation weights.
    localparam int FRAC_BITS = 16;

    // Accumulator for the four weighted corners, and the rounding position.
    localparam int ACC_W     = 66;
    localparam int RND_SHIFT = 32;

    localparam logic [RES_W-1:0] RES_ONE     = 31'd1;
    localparam logic [RES_W-1:0] RES_MAX     = 31'h7FFF_FFFF;
    localparam logic [RES_W-1:0] RES_DEFAULT = 31'd65536;

    // Request codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        ADDR_FIRST,
        ADDR_LAST,
        ADDR_NEXT
    } t_addr_sel;

    typedef enum logic [1:0] {
        LO_HOLD,
        LO_FIRST,
        LO_DATA
    } t_lo_src;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_INC
    } t_idx_op;

    typedef enum logic {
        AXIS_X,
        AXIS_Y
    } t_axis;

    // Corner order: (low x, low y), (high x, low y), (high x, high y), (low x, high y).
    typedef enum logic [1:0] {
        CORNER_LL,
        CORNER_HL,
        CORNER_HH,
        CORNER_LH
    } t_corner;

    typedef struct packed {
        logic      capture;
        t_addr_sel addr_sel;
        t_axis     axis;
        logic      take_first;
        logic      set_inside;
        t_lo_src   lo_src;
        t_idx_op   idx_op;
        logic      div_start;
        logic      frac_store;
        logic      mac_clr;
        logic      mac_issue;
        t_corner   corner;
        logic      round;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic in_grid;
        logic stop;
        logic div_done;
    } t_sts;

endpackage

>>> hw/rtl/gbi_if.sv
// Request and result channel interfaces of the grid bilinear interpolator.
interface gbi_req_if #(
    parameter int COORD_WIDTH = gbi_pkg::COORD_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [gbi_pkg::LOAD_IDX_W-1:0]      row_index;
    logic [gbi_pkg::LOAD_IDX_W-1:0]      col_index;
    logic signed [COORD_WIDTH-1:0]       coord_x;
    logic signed [COORD_WIDTH-1:0]       coord_y;
    logic signed [gbi_pkg::SAMPLE_W-1:0] sample_value;

    modport source (
        output valid, opcode, row_index, col_index, coord_x, coord_y, sample_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, row_index, col_index, coord_x, coord_y, sample_value,
        output ready
    );
endinterface

interface gbi_res_if;
    logic                          valid;
    logic                          ready;
    logic [gbi_pkg::RES_W-1:0]     result_value;
    logic                          inside_grid;

    modport source (
        output valid, result_value, inside_grid,
        input  ready
    );
    modport sink (
        input  valid, result_value, inside_grid,
        output ready
    );
endinterface

>>> hw/rtl/gbi_ram.sv
// Generic simple dual-port RAM with registered read data.
module gbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/gbi_div.sv
// Restoring divider producing a fixed number of fraction bits, one bit per cycle.
module gbi_div #(
    parameter int DW = 33,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);
    localparam int CNTW = $clog2(QW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [QW-1:0]   r_quot;
    logic [DW+1:0]   trial;
    logic            ge;

    // The numerator is below the divisor, so the remainder always stays below it.
    assign trial = {1'b0, r_rem, 1'b0} - {2'b00, r_den};
    assign ge    = !trial[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? trial[DW-1:0] : {r_rem[DW-2:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> hw/rtl/gbi_datapath.sv
// Datapath: grid stores, axis search registers, divider and corner accumulator.
module gbi_datapath #(
    parameter int MAX_ROWS    = gbi_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = gbi_pkg::MAX_COLS_DEF,
    parameter int COORD_WIDTH = gbi_pkg::COORD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gbi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gbi_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_load,
    input  logic [gbi_pkg::LOAD_IDX_W-1:0]      i_row_index,
    input  logic [gbi_pkg::LOAD_IDX_W-1:0]      i_col_index,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_y,
    input  logic signed [gbi_pkg::SAMPLE_W-1:0] i_sample_value,
    input  gbi_pkg::t_cmd                       i_cmd,
    output gbi_pkg::t_sts                       o_sts,
    output logic [gbi_pkg::RES_W-1:0]           o_result_value,
    output logic                                o_inside_grid
);
    import gbi_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int XAW = $clog2(MAX_ROWS);
    localparam int YAW = $clog2(MAX_COLS);
    localparam int IW  = (XAW > YAW) ? XAW : YAW;
    localparam int SAW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int FW  = FRAC_BITS + 1;
    localparam int WW  = 2 * FRAC_BITS + 1;
    localparam int QTW = ACC_W - RND_SHIFT;
    localparam logic [FW-1:0]    W_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [ACC_W-1:0] RND_HALF = {{(ACC_W-RND_SHIFT){1'b0}}, 1'b1,
                                             {(RND_SHIFT-1){1'b0}}};

    // Configuration.
    logic [CFG_W-1:0] r_rows_cfg;
    logic [CFG_W-1:0] r_cols_cfg;

    // Query state.
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic signed [CW-1:0] r_x0;
    logic signed [CW-1:0] r_y0;
    logic signed [CW-1:0] r_lo;
    logic [IW-1:0]        r_last_x;
    logic [IW-1:0]        r_last_y;
    logic [IW-1:0]        n_last_x;
    logic [IW-1:0]        n_last_y;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_xu;
    logic [IW-1:0]        r_yu;
    logic                 r_inside;
    logic [FRAC_BITS-1:0] r_fx;
    logic [FRAC_BITS-1:0] r_fy;

    // Corner pipeline.
    logic [WW-1:0]           r_w;
    logic                    r_w_vld;
    logic signed [ACC_W-1:0] r_p;
    logic                    r_p_vld;
    logic signed [ACC_W-1:0] r_acc;
    logic [RES_W-1:0]        r_res;
    logic [RES_W-1:0]        n_res;

    logic [RES_W-1:0] r_result_value;
    logic             r_inside_grid;

    // Store ports.
    logic                       load_ok;
    logic [XAW-1:0]             x_raddr;
    logic [YAW-1:0]             y_raddr;
    logic [SAW-1:0]             s_raddr;
    logic [SAW-1:0]             s_waddr;
    logic signed [CW-1:0]       x_rdata;
    logic signed [CW-1:0]       y_rdata;
    logic signed [SAMPLE_W-1:0] s_rdata;

    // Search and weights.
    logic [IW-1:0]          idx_next;
    logic signed [CW-1:0]   ax_data;
    logic signed [CW-1:0]   ax_coord;
    logic [IW-1:0]          ax_last;
    logic [DW-1:0]          div_num;
    logic [DW-1:0]          div_den;
    logic                   div_done;
    logic [FRAC_BITS-1:0]   div_quot;
    logic                   xsel;
    logic                   ysel;
    logic [IW-1:0]          crow;
    logic [IW-1:0]          ccol;
    logic [FW-1:0]          wx;
    logic [FW-1:0]          wy;
    logic [ACC_W-1:0]       rsum;
    logic [QTW-1:0]         rq;

    // A count below two acts as two, above the maximum as the maximum.
    always_comb begin
        if (r_rows_cfg < CFG_W'(2)) begin
            n_last_x = IW'(1);
        end else if (32'(r_rows_cfg) > 32'(MAX_ROWS)) begin
            n_last_x = IW'(MAX_ROWS - 1);
        end else begin
            n_last_x = IW'(r_rows_cfg - CFG_W'(1));
        end
        if (r_cols_cfg < CFG_W'(2)) begin
            n_last_y = IW'(1);
        end else if (32'(r_cols_cfg) > 32'(MAX_COLS)) begin
            n_last_y = IW'(MAX_COLS - 1);
        end else begin
            n_last_y = IW'(r_cols_cfg - CFG_W'(1));
        end
    end

    assign load_ok = i_load && (32'(i_row_index) < 32'(MAX_ROWS))
                            && (32'(i_col_index) < 32'(MAX_COLS));
    assign s_waddr = SAW'(i_row_index) * SAW'(MAX_COLS) + SAW'(i_col_index);

    assign idx_next = r_idx + IW'(1);

    always_comb begin
        unique case (i_cmd.addr_sel)
            ADDR_FIRST: begin
                x_raddr = '0;
                y_raddr = '0;
            end
            ADDR_LAST: begin
                x_raddr = XAW'(r_last_x);
                y_raddr = YAW'(r_last_y);
            end
            ADDR_NEXT: begin
                x_raddr = XAW'(idx_next);
                y_raddr = YAW'(idx_next);
            end
            default: begin
                x_raddr = '0;
                y_raddr = '0;
            end
        endcase
    end

    // Corner address: row and column are the upper bracket or the one below it.
    assign xsel    = (i_cmd.corner == CORNER_HL) || (i_cmd.corner == CORNER_HH);
    assign ysel    = (i_cmd.corner == CORNER_HH) || (i_cmd.corner == CORNER_LH);
    assign crow    = xsel ? r_xu : r_xu - IW'(1);
    assign ccol    = ysel ? r_yu : r_yu - IW'(1);
    assign s_raddr = SAW'(crow) * SAW'(MAX_COLS) + SAW'(ccol);
    assign wx      = xsel ? {1'b0, r_fx} : W_ONE - {1'b0, r_fx};
    assign wy      = ysel ? {1'b0, r_fy} : W_ONE - {1'b0, r_fy};

    gbi_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS)) u_x_axis (
        .i_clk   (i_clk),
        .i_we    (load_ok && (i_col_index == '0)),
        .i_waddr (XAW'(i_row_index)),
        .i_wdata (i_coord_x),
        .i_raddr (x_raddr),
        .o_rdata (x_rdata)
    );

    gbi_ram #(.WIDTH(CW), .DEPTH(MAX_COLS)) u_y_axis (
        .i_clk   (i_clk),
        .i_we    (load_ok && (i_row_index == '0)),
        .i_waddr (YAW'(i_col_index)),
        .i_wdata (i_coord_y),
        .i_raddr (y_raddr),
        .o_rdata (y_rdata)
    );

    gbi_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_samples (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr (s_waddr),
        .i_wdata (i_sample_value),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign ax_data  = (i_cmd.axis == AXIS_X) ? x_rdata : y_rdata;
    assign ax_coord = (i_cmd.axis == AXIS_X) ? r_cx : r_cy;
    assign ax_last  = (i_cmd.axis == AXIS_X) ? r_last_x : r_last_y;

    // Both differences are non-negative here, with the numerator below the divisor.
    assign div_num = {ax_coord[CW-1], ax_coord} - {r_lo[CW-1], r_lo};
    assign div_den = {ax_data[CW-1], ax_data} - {r_lo[CW-1], r_lo};

    gbi_div #(.DW(DW), .QW(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_sts.in_grid  = (r_cx > r_x0) && (r_cx < x_rdata)
                         && (r_cy > r_y0) && (r_cy < y_rdata);
    assign o_sts.stop     = (ax_data > ax_coord) || (r_idx == ax_last);
    assign o_sts.div_done = div_done;

    // Round half up at the Q16.16 point, floor at one LSB, saturate.
    assign rsum = r_acc + RND_HALF;
    assign rq   = rsum[ACC_W-1:RND_SHIFT];
    always_comb begin
        if (r_acc[ACC_W-1] || (r_acc == '0) || (rq == '0)) begin
            n_res = RES_ONE;
        end else if (rq > QTW'(RES_MAX)) begin
            n_res = RES_MAX;
        end else begin
            n_res = rq[RES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= CFG_W'(2);
            r_cols_cfg <= CFG_W'(2);
            r_w_vld    <= 1'b0;
            r_p_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROWS: r_rows_cfg <= i_cfg_data;
                    CFG_COLS: r_cols_cfg <= i_cfg_data;
                    default:  r_rows_cfg <= r_rows_cfg;
                endcase
            end
            r_w_vld <= i_cmd.mac_issue;
            r_p_vld <= r_w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cx     <= i_coord_x;
            r_cy     <= i_coord_y;
            r_last_x <= n_last_x;
            r_last_y <= n_last_y;
        end
        if (i_cmd.take_first) begin
            r_x0 <= x_rdata;
            r_y0 <= y_rdata;
        end
        if (i_cmd.set_inside) begin
            r_inside <= o_sts.in_grid;
        end
        unique case (i_cmd.lo_src)
            LO_HOLD:  r_lo <= r_lo;
            LO_FIRST: r_lo <= (i_cmd.axis == AXIS_X) ? r_x0 : r_y0;
            LO_DATA:  r_lo <= ax_data;
            default:  r_lo <= r_lo;
        endcase
        if (i_cmd.capture) begin
            r_idx <= '0;
        end else begin
            unique case (i_cmd.idx_op)
                IDX_HOLD: r_idx <= r_idx;
                IDX_CLR:  r_idx <= '0;
                IDX_INC:  r_idx <= idx_next;
                default:  r_idx <= r_idx;
            endcase
        end
        if (i_cmd.div_start) begin
            if (i_cmd.axis == AXIS_X) begin
                r_xu <= r_idx;
            end else begin
                r_yu <= r_idx;
            end
        end
        if (i_cmd.frac_store) begin
            if (i_cmd.axis == AXIS_X) begin
                r_fx <= div_quot;
            end else begin
                r_fy <= div_quot;
            end
        end
        // The full weight 1.0 times 1.0 needs the 33rd bit.
        r_w <= WW'(wx) * WW'(wy);
        r_p <= $signed({1'b0, r_w}) * s_rdata;
        if (i_cmd.mac_clr) begin
            r_acc <= '0;
        end else if (r_p_vld) begin
            r_acc <= r_acc + r_p;
        end
        if (i_cmd.round) begin
            r_res <= n_res;
        end
        if (i_cmd.out_load) begin
            r_result_value <= r_inside ? r_res : RES_DEFAULT;
            r_inside_grid  <= r_inside;
        end
    end

    assign o_result_value = r_result_value;
    assign o_inside_grid  = r_inside_grid;
endmodule

>>> hw/rtl/gbi_ctrl.sv
// Controller: sequences bounds check, axis searches, divisions and corner blend.
module gbi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_opcode,
    input  logic          i_res_ready,
    input  gbi_pkg::t_sts i_sts,
    output gbi_pkg::t_cmd o_cmd,
    output logic          o_req_ready,
    output logic          o_res_valid
);
    import gbi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BND0,
        S_BND1,
        S_BND2,
        S_XSRCH,
        S_XDIV,
        S_YBEGIN,
        S_YSRCH,
        S_YDIV,
        S_MAC,
        S_ROUND,
        S_FIN
    } t_state;

    localparam logic [2:0] MAC_CORNERS = 3'd4;
    localparam logic [2:0] MAC_LAST    = 3'd5;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_k;
    logic [2:0] n_k;
    logic       r_res_valid;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && (i_req_opcode == OP_QUERY)) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_BND0;
                end
            end
            S_BND0: begin
                o_cmd.addr_sel = ADDR_FIRST;
                n_state        = S_BND1;
            end
            S_BND1: begin
                o_cmd.addr_sel   = ADDR_LAST;
                o_cmd.take_first = 1'b1;
                n_state          = S_BND2;
            end
            S_BND2: begin
                o_cmd.set_inside = 1'b1;
                o_cmd.axis       = AXIS_X;
                if (i_sts.in_grid) begin
                    o_cmd.addr_sel = ADDR_NEXT;
                    o_cmd.idx_op   = IDX_INC;
                    o_cmd.lo_src   = LO_FIRST;
                    n_state        = S_XSRCH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_XSRCH, S_YSRCH: begin
                o_cmd.axis = (r_state == S_XSRCH) ? AXIS_X : AXIS_Y;
                if (i_sts.stop) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.idx_op    = IDX_CLR;
                    n_state         = (r_state == S_XSRCH) ? S_XDIV : S_YDIV;
                end else begin
                    o_cmd.lo_src   = LO_DATA;
                    o_cmd.idx_op   = IDX_INC;
                    o_cmd.addr_sel = ADDR_NEXT;
                end
            end
            S_XDIV: begin
                o_cmd.axis = AXIS_X;
                if (i_sts.div_done) begin
                    o_cmd.frac_store = 1'b1;
                    n_state          = S_YBEGIN;
                end
            end
            S_YBEGIN: begin
                o_cmd.axis     = AXIS_Y;
                o_cmd.addr_sel = ADDR_NEXT;
                o_cmd.idx_op   = IDX_INC;
                o_cmd.lo_src   = LO_FIRST;
                n_state        = S_YSRCH;
            end
            S_YDIV: begin
                o_cmd.axis = AXIS_Y;
                if (i_sts.div_done) begin
                    o_cmd.frac_store = 1'b1;
                    o_cmd.mac_clr    = 1'b1;
                    n_k              = '0;
                    n_state          = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac_issue = (r_k < MAC_CORNERS);
                o_cmd.corner    = t_corner'(r_k[1:0]);
                n_k             = r_k + 3'd1;
                if (r_k == MAC_LAST) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!r_res_valid || i_res_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (o_cmd.out_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
endmodule

>>> hw/rtl/grid_bilinear_interpolator.sv
// Top level of the grid bilinear interpolator: controller, datapath and checks.
//
// The block holds a rectilinear grid of signed Q16.16 samples and answers
// interpolation queries. Requests arrive on i_req; a load request writes one
// grid point (its x coordinate when it is in column 0, its y coordinate when
// it is in row 0, and always its sample). A query request produces exactly
// one result on o_res: the bilinear blend of the four corners around the
// point, or 1.0 with inside_grid low when the point is not strictly inside.
// The user must set the grid counts on the configuration port only while
// the block is idle; the block itself does not enforce this.
// A load leaves the block idle, and the next request can follow at once.
// A query outside the grid goes from the bounds check straight to the output.
// A query inside runs the x search, x division, y search, y division, corner
// blend and rounding. The axis searches read one axis entry per cycle from the
// axis stores up to the last entry in use, and each division retires one
// fraction bit per cycle in the shared divider, which serves both axes.
// Requests are refused while a query is in work. The result sits in an output
// register; the block takes new requests while it waits, and a following
// query stalls only at its end if the previous result is still not taken.
// Reset clears the controller and sets both counts to two; the grid stores
// are not cleared, and points must be loaded before they are queried.
module grid_bilinear_interpolator #(
    parameter int MAX_ROWS    = gbi_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = gbi_pkg::MAX_COLS_DEF,
    parameter int COORD_WIDTH = gbi_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gbi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gbi_pkg::CFG_W-1:0]     i_cfg_data,
    gbi_req_if.sink                       i_req,
    gbi_res_if.source                     o_res
);
    import gbi_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic req_ready;
    logic req_accept;

    assign i_req.ready = req_ready;
    assign req_accept  = i_req.valid && req_ready;

    // The controller sequences each query; the datapath holds all grid data.
    gbi_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_opcode (i_req.opcode),
        .i_res_ready  (o_res.ready),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_req_ready  (req_ready),
        .o_res_valid  (o_res.valid)
    );

    // Loads write the stores directly on the accepting edge.
    gbi_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_load         (req_accept && (i_req.opcode == OP_LOAD)),
        .i_row_index    (i_req.row_index),
        .i_col_index    (i_req.col_index),
        .i_coord_x      (i_req.coord_x),
        .i_coord_y      (i_req.coord_y),
        .i_sample_value (i_req.sample_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_value (o_res.result_value),
        .o_inside_grid  (o_res.inside_grid)
    );

    // An accepted query holds off further requests while it is worked on.
    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && (i_req.opcode == OP_QUERY)) |=> !i_req.ready)
        else $error("request taken while a query is in work");

    // A load never takes the block out of the idle state.
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && (i_req.opcode == OP_LOAD)) |=> i_req.ready)
        else $error("load request did not complete in one cycle");

    // A query outside the grid answers exactly 1.0.
    a_default_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.inside_grid) |-> (o_res.result_value == RES_DEFAULT))
        else $error("outside result is not 1.0");

    // Results are floored at one LSB.
    a_result_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.result_value != '0))
        else $error("result below one LSB");
endmodule
